### design/shadow_queue_ecn_marker_core_defines.svh
// Assertion macros for the marker core source.
`ifndef SHADOW_QUEUE_ECN_MARKER_CORE_DEFINES_SVH
`define SHADOW_QUEUE_ECN_MARKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SQEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SQEM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SQEM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SQEM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/sqem_pkg.sv
package sqem_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROB    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EWMA_WEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ECN_ENABLE  = 3'd5;

	localparam logic [15:0] RST_QUEUE_LIMIT = 16'd1000;
	localparam logic [19:0] RST_INTERVAL    = 20'd10000;
	localparam logic [16:0] RST_MAX_PROB    = 17'd52428;
	localparam logic [16:0] RST_EWMA_WEIGHT = 17'd64225;
	localparam logic [22:0] RST_LINK_RATE   = 23'd125000;
	localparam logic        RST_ECN_ENABLE  = 1'b1;

	localparam logic [16:0] Q16_ONE       = 17'h10000;
	localparam logic [31:0] PROB_ALL_ONES = 32'hFFFF_FFFF;

	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 23;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int unsigned KDIV_IN_W    = 55;
	localparam int unsigned KDIV_PAD_W   = 56;
	localparam int unsigned KDIV_REM_W   = 10;
	localparam int unsigned KDIV_DIGIT_W = 4;
	localparam int unsigned KDIV_STEPS   = KDIV_PAD_W / KDIV_DIGIT_W;
	localparam int unsigned KDIV_CNT_W   = 4;
	localparam logic [KDIV_REM_W-1:0] KDIV_DIVISOR = 10'd1000;

	localparam int unsigned NUM_W = 64;
	localparam int unsigned DEN_W = 46;
	localparam int unsigned QUO_W = 32;

	typedef enum logic [1:0] {
		VERDICT_PASS = 2'd0,
		VERDICT_MARK = 2'd1,
		VERDICT_DROP = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [15:0] packet_bytes;
		logic [15:0] queue_packets;
		logic [31:0] backlog_bytes;
		logic [31:0] now_us;
		logic [31:0] random_word;
		logic        ecn_capable;
	} in_item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] mark_probability;
		logic        prob_refreshed;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

### design/sqem_mul.sv
module sqem_mul (
	input  logic                             clk,
	input  logic [sqem_pkg::MUL_A_W-1:0] a,
	input  logic [sqem_pkg::MUL_B_W-1:0] b,
	output logic [sqem_pkg::MUL_P_W-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

### design/sqem_kdiv.sv
module sqem_kdiv (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [sqem_pkg::KDIV_IN_W-1:0]     dividend,
	output sqem_pkg::unit_sts_t                sts,
	output logic [sqem_pkg::DEN_W-1:0]         quotient
);

	localparam int unsigned PW = sqem_pkg::KDIV_PAD_W;
	localparam int unsigned RW = sqem_pkg::KDIV_REM_W;
	localparam int unsigned DW = sqem_pkg::KDIV_DIGIT_W;
	localparam int unsigned QW = sqem_pkg::DEN_W;
	localparam int unsigned CW = sqem_pkg::KDIV_CNT_W;
	localparam logic [CW-1:0] LAST = CW'(sqem_pkg::KDIV_STEPS - 1);

	logic [PW-1:0] dvd_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] rem_nxt;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] digit;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_comb begin
		logic [RW:0]   trial;
		logic [RW-1:0] r;
		r     = rem_q;
		digit = '0;
		for (int i = 0; i < DW; i++) begin
			trial = {r, dvd_q[PW-1-i]};
			if (trial >= {1'b0, sqem_pkg::KDIV_DIVISOR}) begin
				trial = trial - {1'b0, sqem_pkg::KDIV_DIVISOR};
				digit[DW-1-i] = 1'b1;
			end
			r = trial[RW-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= PW'(dividend);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DW;
			rem_q <= rem_nxt;
			quo_q <= {quo_q[QW-DW-1:0], digit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

### design/sqem_div.sv
module sqem_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sqem_pkg::NUM_W-1:0]     num,
	input  logic [sqem_pkg::DEN_W-1:0]     den,
	output sqem_pkg::unit_sts_t            sts,
	output logic [sqem_pkg::QUO_W-1:0]     quotient,
	output logic                           over
);

	localparam int unsigned NW = sqem_pkg::NUM_W;
	localparam int unsigned DW = sqem_pkg::DEN_W;
	localparam int unsigned QW = sqem_pkg::QUO_W;
	localparam int unsigned CW = $clog2(QW);
	localparam logic [CW-1:0] LAST = CW'(QW - 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] dq_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          over_q;
	logic          over_now;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;
	logic [DW-1:0] rem_nxt;

	assign over_now = DW'(num[NW-1:QW]) >= den;
	assign trial    = {rem_q, dq_q[QW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fits     = trial >= {1'b0, den_q};
	assign rem_nxt  = fits ? diff[DW-1:0] : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			over_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				over_q <= over_now;
				cnt_q  <= '0;
				if (over_now) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num[NW-1:QW]);
			den_q <= den;
			dq_q  <= num[QW-1:0];
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[QW-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;
	assign over     = over_q;

endmodule

### design/shadow_queue_ecn_marker_core.sv
// Channel  Handshake               Transaction
// in       in_valid / in_stall     one arriving packet (in_data)
// out      out_valid / out_stall   one verdict with probability (out_data)
// cfg      cfg_wr_en               one register write (cfg_index, cfg_wdata)
//
// A packet without refresh passes S_CHECK, S_DECIDE and S_DONE from acceptance
// to a loaded result; a dropped packet skips S_DECIDE.
// A refresh runs six products on the shared 33x23 multiplier, then the divide
// by 1000 at four bits a step, then the restoring divider at one quotient bit
// a step (no steps when the quotient saturates).
// Asynchronous reset loads register defaults and clears all queue state.
// in_stall is high while a packet is at work; the result register holds until
// taken, and the next packet is accepted while it waits.

`include "shadow_queue_ecn_marker_core_defines.svh"

module shadow_queue_ecn_marker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  sqem_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output sqem_pkg::out_item_t                 out_data,
	input  logic                                cfg_wr_en,
	input  logic [sqem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sqem_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int unsigned AW = sqem_pkg::MUL_A_W;
	localparam int unsigned BW = sqem_pkg::MUL_B_W;
	localparam int unsigned PW = sqem_pkg::MUL_P_W;
	localparam int unsigned ACC_W = 51;

	localparam logic [2:0] OP_LO_KEEP = 3'd0;
	localparam logic [2:0] OP_HI_KEEP = 3'd1;
	localparam logic [2:0] OP_SAMPLE  = 3'd2;
	localparam logic [2:0] OP_AVG_HI  = 3'd3;
	localparam logic [2:0] OP_AVG_LO  = 3'd4;
	localparam logic [2:0] OP_BW      = 3'd5;
	localparam int unsigned MUL_OPS = 6;
	localparam logic [3:0] MUL_LAST = 4'(2 * MUL_OPS - 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_KDIV   = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_DECIDE = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0] queue_limit_q;
	logic [19:0] interval_q;
	logic [16:0] max_prob_q;
	logic [16:0] ewma_weight_q;
	logic [22:0] link_q;
	logic        ecn_q;

	logic [47:0] avg_q;
	logic [31:0] bytes_q;
	logic [31:0] last_q;
	logic [31:0] prob_q;

	sqem_pkg::in_item_t  item_q;
	sqem_pkg::out_item_t out_q;
	logic                out_valid_q;
	sqem_pkg::verdict_t  verdict_q;
	logic                refreshed_q;

	logic [16:0]      alpha_q;
	logic [16:0]      keep_q;
	logic [16:0]      maxp_q;
	logic [31:0]      elapsed_q;
	logic [AW-1:0]    sample_q;
	logic [ACC_W-1:0] acc_q;
	logic [sqem_pkg::NUM_W-1:0] num_q;
	logic [3:0]       mstep_q;

	logic        in_accept;
	logic        out_free;
	logic [16:0] alpha_c;
	logic [16:0] maxp_c;
	logic        drop_c;
	logic [32:0] bytes_sum;
	logic [31:0] bytes_sat;
	logic [31:0] elapsed_c;
	logic        refresh_c;
	logic [2:0]  mul_op;
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] mul_prod;
	logic [ACC_W-1:0] avg_sum;
	logic [47:0] avg_sat;
	logic        kdiv_start;
	logic        div_start;
	sqem_pkg::unit_sts_t kdiv_sts;
	sqem_pkg::unit_sts_t div_sts;
	logic [sqem_pkg::DEN_W-1:0] kdiv_quo;
	logic [sqem_pkg::QUO_W-1:0] div_quo;
	logic        div_over;
	logic [31:0] prob_new;
	logic        mark_c;

	assign in_accept = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign alpha_c = (ewma_weight_q > sqem_pkg::Q16_ONE) ? sqem_pkg::Q16_ONE : ewma_weight_q;
	assign maxp_c  = (max_prob_q > sqem_pkg::Q16_ONE) ? sqem_pkg::Q16_ONE : max_prob_q;

	assign drop_c    = item_q.queue_packets >= queue_limit_q;
	assign bytes_sum = {1'b0, bytes_q} + 33'(item_q.packet_bytes);
	assign bytes_sat = bytes_sum[32] ? '1 : bytes_sum[31:0];
	assign elapsed_c = item_q.now_us - last_q;
	assign refresh_c = 32'(interval_q) < elapsed_c;

	assign mul_op = mstep_q[3:1];

	always_comb begin
		unique case (mul_op)
			OP_LO_KEEP: begin
				mul_a = AW'(avg_q[15:0]);
				mul_b = BW'(keep_q);
			end
			OP_HI_KEEP: begin
				mul_a = AW'(avg_q[47:16]);
				mul_b = BW'(keep_q);
			end
			OP_SAMPLE: begin
				mul_a = sample_q;
				mul_b = BW'(alpha_q);
			end
			OP_AVG_HI: begin
				mul_a = AW'(avg_q[47:16]);
				mul_b = BW'(maxp_q);
			end
			OP_AVG_LO: begin
				mul_a = AW'(avg_q[15:0]);
				mul_b = BW'(maxp_q);
			end
			OP_BW: begin
				mul_a = AW'(elapsed_q);
				mul_b = link_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sqem_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	assign avg_sum = acc_q + mul_prod[ACC_W-1:0];
	assign avg_sat = (|avg_sum[ACC_W-1:48]) ? '1 : avg_sum[47:0];

	assign kdiv_start = (state_q == S_MUL) && (mstep_q == MUL_LAST);
	assign div_start  = (state_q == S_KDIV) && kdiv_sts.done;

	sqem_kdiv u_kdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (kdiv_start),
		.dividend (mul_prod[sqem_pkg::KDIV_IN_W-1:0]),
		.sts      (kdiv_sts),
		.quotient (kdiv_quo)
	);

	sqem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_q),
		.den      (kdiv_quo),
		.sts      (div_sts),
		.quotient (div_quo),
		.over     (div_over)
	);

	assign prob_new = (div_over || ({1'b0, div_quo} >= {maxp_q, 16'h0000}))
		? sqem_pkg::PROB_ALL_ONES : div_quo;

	assign mark_c = (item_q.random_word < prob_q) && ecn_q && item_q.ecn_capable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			queue_limit_q <= sqem_pkg::RST_QUEUE_LIMIT;
			interval_q    <= sqem_pkg::RST_INTERVAL;
			max_prob_q    <= sqem_pkg::RST_MAX_PROB;
			ewma_weight_q <= sqem_pkg::RST_EWMA_WEIGHT;
			link_q        <= sqem_pkg::RST_LINK_RATE;
			ecn_q         <= sqem_pkg::RST_ECN_ENABLE;
			avg_q         <= '0;
			bytes_q       <= '0;
			last_q        <= '0;
			prob_q        <= '0;
			out_valid_q   <= 1'b0;
			mstep_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					sqem_pkg::CFG_QUEUE_LIMIT: queue_limit_q <= cfg_wdata[15:0];
					sqem_pkg::CFG_INTERVAL:    interval_q    <= cfg_wdata[19:0];
					sqem_pkg::CFG_MAX_PROB:    max_prob_q    <= cfg_wdata[16:0];
					sqem_pkg::CFG_EWMA_WEIGHT: ewma_weight_q <= cfg_wdata[16:0];
					sqem_pkg::CFG_LINK_RATE:   link_q        <= cfg_wdata[22:0];
					sqem_pkg::CFG_ECN_ENABLE:  ecn_q         <= cfg_wdata[0];
					default: ;
				endcase
			end

			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (drop_c) begin
						state_q <= S_DONE;
					end else begin
						bytes_q <= bytes_sat;
						if (refresh_c) begin
							mstep_q <= '0;
							state_q <= S_MUL;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q[0] && (mul_op == OP_SAMPLE)) avg_q <= avg_sat;
					if (kdiv_start) begin
						bytes_q <= '0;
						last_q  <= item_q.now_us;
						state_q <= S_KDIV;
					end
				end
				S_KDIV: begin
					if (kdiv_sts.done) state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						prob_q  <= prob_new;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) item_q <= in_data;

		if (state_q == S_CHECK) begin
			alpha_q     <= alpha_c;
			keep_q      <= sqem_pkg::Q16_ONE - alpha_c;
			maxp_q      <= maxp_c;
			elapsed_q   <= elapsed_c;
			verdict_q   <= sqem_pkg::VERDICT_DROP;
			refreshed_q <= !drop_c && refresh_c;
		end

		if (state_q == S_MUL) begin
			if (mstep_q == 4'd0) begin
				sample_q <= AW'(bytes_q) + AW'(item_q.backlog_bytes);
			end
			if (mstep_q[0]) begin
				unique case (mul_op)
					OP_LO_KEEP: acc_q <= ACC_W'(mul_prod[32:16]);
					OP_HI_KEEP: acc_q <= acc_q + mul_prod[ACC_W-1:0];
					OP_AVG_HI:  num_q <= {mul_prod[47:0], 16'h0000};
					OP_AVG_LO:  num_q <= num_q + sqem_pkg::NUM_W'(mul_prod);
					default: ;
				endcase
			end
		end

		if (state_q == S_DECIDE) begin
			verdict_q <= mark_c ? sqem_pkg::VERDICT_MARK : sqem_pkg::VERDICT_PASS;
		end

		if ((state_q == S_DONE) && out_free) begin
			out_q.verdict          <= verdict_q;
			out_q.mark_probability <= prob_q;
			out_q.prob_refreshed   <= refreshed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SQEM_ASSERT_IMP(a_drop_no_refresh, clk, arst_n, out_valid && (out_data.verdict == sqem_pkg::VERDICT_DROP), !out_data.prob_refreshed)
	`SQEM_ASSERT_IMP(a_kdiv_done_state, clk, arst_n, kdiv_sts.done, state_q == S_KDIV)
	`SQEM_ASSERT_IMP(a_div_done_state, clk, arst_n, div_sts.done, state_q == S_DIV)
	`SQEM_ASSERT_NXT(a_accept_check, clk, arst_n, in_valid && !in_stall, state_q == S_CHECK)

endmodule
